// ===== sv/wrm_pkg.sv =====
// Shared types, codes and character helpers for the word redaction matcher.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package wrm_pkg;

  localparam int BYTE_W  = 8;
  localparam int MODE_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int INDEX_W = 4;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  // Redaction register codes.
  localparam logic [1:0] RM_WORDS = 2'd0;
  localparam logic [1:0] RM_ALL   = 2'd1;
  localparam logic [1:0] RM_ALNUM = 2'd2;

  localparam logic [BYTE_W-1:0] MASK_CHAR = 8'd35;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_REBUILD
  } state_t;

  // One position of the text delay line.
  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              valid;
    logic              mark;
  } cell_data_t;

  // Advance command for the per-word prefix trackers.
  typedef struct packed {
    logic              step;
    logic              clear;
    logic              valid;
    logic [BYTE_W-1:0] ch;
  } row_step_t;

  // Pattern character write.
  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [BYTE_W-1:0]  ch;
    logic               last;
  } row_load_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_last;
    logic              nothing_held;
  } out_item_t;

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

endpackage

`default_nettype wire

// ===== sv/wrm_text_cell.sv =====
// One position of the text delay line: byte, held flag and redaction mark.
// Depends on wrm_pkg for the cell data type.
`default_nettype none

module wrm_text_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  wrm_pkg::cell_data_t d_in,
  input  logic                cover_in,
  output wrm_pkg::cell_data_t q
);
  import wrm_pkg::*;

  logic [BYTE_W-1:0] ch;
  logic              valid;
  logic              mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      mark  <= 1'b0;
    end else if (shift) begin
      valid <= d_in.valid;
      mark  <= d_in.mark | cover_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      ch <= d_in.ch;
    end
  end

  assign q = '{ch: ch, valid: valid, mark: mark};

endmodule

`default_nettype wire

// ===== sv/wrm_word_row.sv =====
// One pattern word: its folded characters, its length and a row of prefix
// flags that track how much of the word ends at the newest text byte.
// Depends on wrm_pkg for the load and step types.
`default_nettype none

module wrm_word_row #(
  parameter int MAX_WORD_LEN = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load_en,
  input  wrm_pkg::row_load_t                   ld,
  input  wrm_pkg::row_step_t                   st,
  output logic                                 hit,
  output logic [$clog2(MAX_WORD_LEN+1)-1:0]    len
);
  import wrm_pkg::*;

  localparam int LW = $clog2(MAX_WORD_LEN + 1);
  localparam int IW = $clog2(MAX_WORD_LEN);

  logic [BYTE_W-1:0]       pat [MAX_WORD_LEN];
  logic [MAX_WORD_LEN-1:0] part;
  logic [MAX_WORD_LEN-1:0] part_next;
  logic [LW-1:0]           len_q;

  // Flag k is set when the newest k+1 bytes equal the first k+1 characters.
  for (genvar k = 0; k < MAX_WORD_LEN; k++) begin : g_flag
    if (k == 0) begin : g_head
      assign part_next[k] = st.valid && (st.ch == pat[k]);
    end else begin : g_tail
      assign part_next[k] = st.valid && part[k-1] && (st.ch == pat[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      if (load_en && (32'(ld.idx) == k)) begin
        pat[k] <= ld.ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_q <= '0;
    end else if (load_en && ld.last) begin
      len_q <= LW'(32'(ld.idx) + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || st.clear) begin
      part <= '0;
    end else if (st.step) begin
      part <= part_next;
    end
  end

  assign hit = st.step && (len_q != '0) && part_next[IW'(len_q - LW'(1))];
  assign len = len_q;

endmodule

`default_nettype wire

// ===== sv/wrm_out_fifo.sv =====
// Two-entry result queue between the matcher and the output channel.
// Depends on wrm_pkg for the result item type.
`default_nettype none

module wrm_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wrm_pkg::out_item_t push_item,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output wrm_pkg::out_item_t out_item
);
  import wrm_pkg::*;

  out_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/word_redaction_matcher_core.sv =====
// Streaming word redactor: a text byte request is taken every cycle unless a replay
// is pending or the result queue is full; the byte it pushes out of the MAX_WORD_LEN
// deep delay line goes into the result queue. A flush request walks the line out.
// After a pattern load into a non-empty line, the next text byte waits while
// the line is replayed through the word trackers.
// Synchronous reset empties the line, clears all word lengths and the register.
`default_nettype none

module word_redaction_matcher_core #(
  parameter int MAX_WORDS    = 8,
  parameter int MAX_WORD_LEN = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [wrm_pkg::MODE_W-1:0]  mode,
  input  logic [wrm_pkg::BYTE_W-1:0]  data_byte,
  input  logic [wrm_pkg::SLOT_W-1:0]  word_slot,
  input  logic [wrm_pkg::INDEX_W-1:0] char_index,
  input  logic                        word_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wrm_pkg::BYTE_W-1:0]  out_byte,
  output logic                        is_last,
  output logic                        nothing_held
);
  import wrm_pkg::*;

  localparam int LW = $clog2(MAX_WORD_LEN + 1);
  localparam int IW = $clog2(MAX_WORD_LEN);

  state_t state;
  state_t state_next;
  logic   [1:0] redact_mode;
  logic   dirty;
  logic   [IW-1:0] cnt;

  cell_data_t cell_q  [MAX_WORD_LEN];
  cell_data_t cell_in [MAX_WORD_LEN];
  cell_data_t head_in;
  cell_data_t top;
  cell_data_t below;
  logic [MAX_WORD_LEN-1:0] cover_bits;
  logic [MAX_WORD_LEN-1:0] cover_raw;
  logic [MAX_WORD_LEN-1:0] valid_vec;

  logic [MAX_WORDS-1:0] hit;
  logic [MAX_WORDS-1:0] load_en;
  logic [LW-1:0]        row_len [MAX_WORDS];
  row_load_t            ld;
  row_step_t            st;

  logic      shift;
  logic      text_step;
  logic      load_go;
  logic      load_in_range;
  logic      dirty_set;
  logic      dirty_clr;
  logic      cnt_clr;
  logic      cnt_inc;
  logic      push;
  logic      hide;
  logic      fifo_full;
  out_item_t push_item;
  out_item_t out_item;

  assign top   = cell_q[MAX_WORD_LEN-1];
  assign below = cell_q[MAX_WORD_LEN-2];

  // ---------------------------------------------------------------- delay line
  for (genvar j = 0; j < MAX_WORD_LEN; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign cell_in[j] = head_in;
    end else begin : g_link
      assign cell_in[j] = cell_q[j-1];
    end
    assign valid_vec[j] = cell_q[j].valid;

    wrm_text_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .d_in     (cell_in[j]),
      .cover_in (cover_bits[j]),
      .q        (cell_q[j])
    );
  end

  // ---------------------------------------------------------------- word rows
  assign load_in_range = (32'(word_slot) < MAX_WORDS) && (32'(char_index) < MAX_WORD_LEN);
  assign ld = '{idx: char_index, ch: fold_case(data_byte), last: word_end};

  for (genvar w = 0; w < MAX_WORDS; w++) begin : g_word
    assign load_en[w] = load_go && load_in_range && (32'(word_slot) == w);

    wrm_word_row #(
      .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_row (
      .clk     (clk),
      .rst     (rst),
      .load_en (load_en[w]),
      .ld      (ld),
      .st      (st),
      .hit     (hit[w]),
      .len     (row_len[w])
    );
  end

  // A matching word covers the newest len positions of the line.
  always_comb begin
    cover_raw = '0;
    for (int j = 0; j < MAX_WORD_LEN; j++) begin
      for (int w = 0; w < MAX_WORDS; w++) begin
        if (hit[w] && (32'(row_len[w]) > j)) begin
          cover_raw[j] = 1'b1;
        end
      end
    end
  end

  assign cover_bits = text_step ? cover_raw : '0;

  // ---------------------------------------------------------------- emitted byte
  always_comb begin
    unique case (redact_mode)
      RM_WORDS: hide = top.mark;
      RM_ALL:   hide = 1'b1;
      RM_ALNUM: hide = top.mark || is_alnum(top.ch);
      default:  hide = top.mark;
    endcase
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && (mode == MODE_TEXT) && dirty) begin
          state_next = ST_REBUILD;
        end else if (in_valid && (mode == MODE_FLUSH) && !fifo_full && cell_q[0].valid) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!fifo_full && top.valid && !below.valid) begin
          state_next = ST_IDLE;
        end
      end
      ST_REBUILD: begin
        if (cnt == IW'(MAX_WORD_LEN - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    shift     = 1'b0;
    text_step = 1'b0;
    load_go   = 1'b0;
    dirty_set = 1'b0;
    dirty_clr = 1'b0;
    cnt_clr   = 1'b0;
    cnt_inc   = 1'b0;
    push      = 1'b0;
    head_in   = '{ch: data_byte, valid: 1'b0, mark: 1'b0};
    st        = '{step: 1'b0, clear: 1'b0, valid: 1'b0, ch: fold_case(data_byte)};
    push_item = '{out_byte: (hide ? MASK_CHAR : top.ch), is_last: 1'b0, nothing_held: 1'b0};
    unique case (state)
      ST_IDLE: begin
        unique case (mode)
          MODE_LOAD: begin
            in_stall = 1'b0;
            load_go  = in_valid;
            // Trackers were built against the old pattern; replay before more text.
            dirty_set = in_valid && load_in_range && cell_q[0].valid;
          end
          MODE_TEXT: begin
            in_stall = dirty || fifo_full;
            if (in_valid && !dirty && !fifo_full) begin
              text_step     = 1'b1;
              shift         = 1'b1;
              head_in.valid = 1'b1;
              st.step       = 1'b1;
              st.valid      = 1'b1;
              push          = top.valid;
            end
            if (in_valid && dirty) begin
              st.clear = 1'b1;
              cnt_clr  = 1'b1;
            end
          end
          MODE_FLUSH: begin
            in_stall = fifo_full;
            if (in_valid && !fifo_full) begin
              st.clear = 1'b1;
              if (!cell_q[0].valid) begin
                push      = 1'b1;
                push_item = '{out_byte: '0, is_last: 1'b0, nothing_held: 1'b1};
              end
            end
          end
          MODE_NONE: in_stall = 1'b0;
          default:   in_stall = 1'b0;
        endcase
      end
      ST_FLUSH: begin
        if (!fifo_full) begin
          shift             = 1'b1;
          st.step           = 1'b1;
          push              = top.valid;
          push_item.is_last = !below.valid;
          dirty_clr         = top.valid && !below.valid;
        end
      end
      ST_REBUILD: begin
        // Rotate the line once around, feeding the oldest byte first.
        shift     = 1'b1;
        head_in   = top;
        st.step   = 1'b1;
        st.valid  = top.valid;
        st.ch     = fold_case(top.ch);
        cnt_inc   = 1'b1;
        dirty_clr = (cnt == IW'(MAX_WORD_LEN - 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      redact_mode <= RM_WORDS;
      dirty       <= 1'b0;
      cnt         <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        redact_mode <= cfg_wdata;
      end
      if (dirty_clr) begin
        dirty <= 1'b0;
      end else if (dirty_set) begin
        dirty <= 1'b1;
      end
      if (cnt_clr) begin
        cnt <= '0;
      end else if (cnt_inc) begin
        cnt <= cnt + IW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- output queue
  wrm_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign out_byte     = out_item.out_byte;
  assign is_last      = out_item.is_last;
  assign nothing_held = out_item.nothing_held;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_full)
    else $error("result pushed into a full queue");

  a_line_packed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("held bytes are not packed at the newest end of the line");

  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !cell_q[0].valid) |-> !dirty)
    else $error("replay pending on an empty line");

  a_text_fresh: assert property (@(posedge clk) disable iff (rst)
    text_step |-> (!dirty && state == ST_IDLE))
    else $error("text byte matched against stale word trackers");
`endif

endmodule

`default_nettype wire
